### rtl/sgdmf_pkg.sv
package sgdmf_pkg;

	localparam int ROWS    = 1024;
	localparam int COLS    = 1024;
	localparam int FACTORS = 40;
	localparam int ROW_W   = 10;
	localparam int COL_W   = 10;
	localparam int FAC_W   = 6;
	localparam int ROW_AW  = $clog2(ROWS * FACTORS);
	localparam int COL_AW  = $clog2(COLS * FACTORS);

	localparam logic [23:0] LEARN_RATE_RST = 24'd50332;
	localparam logic [23:0] REG_RST        = 24'd1677722;

	localparam logic CFG_LEARN_RATE = 1'b0;
	localparam logic CFG_REG        = 1'b1;

	typedef enum logic [2:0] {
		MODE_WR_ROW = 3'd0,
		MODE_WR_COL = 3'd1,
		MODE_TRAIN  = 3'd2,
		MODE_RD_ROW = 3'd3,
		MODE_RD_COL = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DOT,
		ST_ERR,
		ST_UPD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic [9:0]         row_index;
		logic [9:0]         col_index;
		logic [5:0]         factor_index;
		logic signed [31:0] value;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               saturated;
	} out_word_t;

	// control from sequencer to the cell row
	typedef struct packed {
		logic shift;   // shift vectors one place down the chain
		logic clr_acc;
		logic acc_en;
		logic upd;     // tail pair enters the update pipeline
	} cell_ctrl_t;

	function automatic logic signed [31:0] clip32(input logic signed [63:0] v,
		output logic flag);
		logic signed [31:0] r;
		flag = 1'b0;
		r = v[31:0];
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
			flag = 1'b1;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
			flag = 1'b1;
		end
		return r;
	endfunction

endpackage

### rtl/sgdmf_cell.sv
// one cell of the factor chain: holds one p/q pair, passes it on each shift
module sgdmf_cell import sgdmf_pkg::*; (
	input  logic               clk,
	input  cell_ctrl_t         ctrl,
	input  logic signed [31:0] p_in,
	input  logic signed [31:0] q_in,
	output logic signed [31:0] p_out,
	output logic signed [31:0] q_out
);

	logic signed [31:0] p_q, q_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			p_q <= p_in;
			q_q <= q_in;
		end
	end

	assign p_out = p_q;
	assign q_out = q_q;

endmodule

### rtl/sgdmf_mac.sv
// shared arithmetic: product for the dot sum, and the two factor updates
module sgdmf_mac import sgdmf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctrl_t         ctrl,
	input  logic signed [31:0] p,
	input  logic signed [31:0] q,
	input  logic signed [31:0] err,
	input  logic [23:0]        alpha,
	input  logic [23:0]        beta,
	output logic signed [63:0] sum,
	output logic signed [31:0] p_new,
	output logic signed [31:0] q_new,
	output logic               sat
);

	logic signed [63:0] prod, ep, eq, bp, bq;
	logic signed [63:0] dp, dq, sp, sq;
	logic signed [63:0] rp, rq;
	logic signed [63:0] acc_q;
	logic signed [63:0] dp_s1, dq_s1;
	logic signed [31:0] p_s1, q_s1;
	logic upd_s1;
	logic fp, fq;

	assign prod = p * q;
	// first update stage: e*other - beta*self, rounded to Q.24
	assign eq   = 64'(err) * 64'(q);
	assign ep   = 64'(err) * 64'(p);
	assign bp   = $signed({40'd0, beta}) * 64'(p);
	assign bq   = $signed({40'd0, beta}) * 64'(q);
	assign dp   = (eq - bp + 64'sd8388608) >>> 24;
	assign dq   = (ep - bq + 64'sd8388608) >>> 24;
	// second update stage: scale by alpha, add to the old value, clip
	assign sp   = ($signed({40'd0, alpha}) * dp_s1 + 64'sd8388608) >>> 24;
	assign sq   = ($signed({40'd0, alpha}) * dq_s1 + 64'sd8388608) >>> 24;
	assign rp   = 64'(p_s1) + sp;
	assign rq   = 64'(q_s1) + sq;

	always_comb begin
		p_new = clip32(rp, fp);
		q_new = clip32(rq, fq);
	end

	always_ff @(posedge clk) begin
		if (ctrl.upd) begin
			dp_s1 <= dp;
			dq_s1 <= dq;
			p_s1  <= p;
			q_s1  <= q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			sat    <= 1'b0;
			upd_s1 <= 1'b0;
		end else begin
			upd_s1 <= ctrl.upd;
			if (ctrl.clr_acc) begin
				acc_q <= '0;
				sat   <= 1'b0;
			end else begin
				if (ctrl.acc_en)
					acc_q <= acc_q + ((prod + 64'sd8388608) >>> 24);
				if (upd_s1 && (fp || fq))
					sat <= 1'b1;
			end
		end
	end

	assign sum = acc_q;

endmodule

### rtl/sgd_matrix_factor_update.sv
// One item per start pulse; busy stays high until the single result strobe.
// In a train item, FACTORS memory reads feed a chain of FACTORS cells
// while one multiply-accumulate forms the dot sum, then the vectors
// cycle through the chain again through the shared two-stage update unit
// and are written back, one factor per cycle on each table's write port.
// Tables are undefined until written. The result is shown for exactly one
// cycle on done; the receiver cannot stall it. Write configuration only
// while busy is low.
module sgd_matrix_factor_update import sgdmf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_word_t    in_word,
	output logic        done,
	output out_word_t   out_word,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data
);

	state_t state_q, state_nx;
	in_word_t item_q;
	logic [23:0] alpha_q, beta_q;
	logic [FAC_W:0] cnt_q;
	logic signed [31:0] err_q, res_q;
	logic esat_q;
	logic signed [31:0] row_mem [ROWS*FACTORS];
	logic signed [31:0] col_mem [COLS*FACTORS];
	logic signed [31:0] prd_q, crd_q;
	logic [ROW_AW-1:0] rbase, raddr;
	logic [COL_AW-1:0] cbase, caddr;
	logic rd_vld_s1;
	cell_ctrl_t ctrl;
	logic signed [31:0] pch [FACTORS+1];
	logic signed [31:0] qch [FACTORS+1];
	logic signed [63:0] sum;
	logic signed [31:0] p_new, q_new, err_c;
	logic usat, ef;
	logic row_ok, col_ok, fac_ok;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= LEARN_RATE_RST;
			beta_q  <= REG_RST;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_LEARN_RATE) alpha_q <= cfg_data;
			else beta_q <= cfg_data;
		end
	end

	assign row_ok = 32'(item_q.row_index) < ROWS;
	assign col_ok = 32'(item_q.col_index) < COLS;
	assign fac_ok = 32'(item_q.factor_index) < FACTORS;
	assign rbase  = ROW_AW'(32'(item_q.row_index) * FACTORS);
	assign cbase  = COL_AW'(32'(item_q.col_index) * FACTORS);

	// memory address: factor index outside train mode, element counter during train sweeps
	always_comb begin
		raddr = rbase + ROW_AW'(item_q.factor_index);
		caddr = cbase + COL_AW'(item_q.factor_index);
		if (item_q.mode == MODE_TRAIN) begin
			raddr = rbase + ROW_AW'(cnt_q);
			caddr = cbase + COL_AW'(cnt_q);
		end
	end

	// chain: memory data enters at head; in ST_UPD the updated tail data re-enters at head
	assign pch[0] = (state_q == ST_UPD) ? p_new : prd_q;
	assign qch[0] = (state_q == ST_UPD) ? q_new : crd_q;
	genvar g;
	generate
		for (g = 0; g < FACTORS; g++) begin : g_cell
			sgdmf_cell u_cell (
				.clk(clk), .ctrl(ctrl),
				.p_in(pch[g]), .q_in(qch[g]),
				.p_out(pch[g+1]), .q_out(qch[g+1])
			);
		end
	endgenerate

	sgdmf_mac u_mac (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl),
		.p(state_q == ST_UPD ? pch[FACTORS] : prd_q),
		.q(state_q == ST_UPD ? qch[FACTORS] : crd_q),
		.err(err_q), .alpha(alpha_q), .beta(beta_q),
		.sum(sum), .p_new(p_new), .q_new(q_new), .sat(usat)
	);

	// memories: read registered; write-back lags the update counter by one
	always_ff @(posedge clk) begin
		prd_q <= row_mem[raddr];
		crd_q <= col_mem[caddr];
		if (state_q == ST_READ && item_q.mode == MODE_WR_ROW && row_ok && fac_ok)
			row_mem[raddr] <= item_q.value;
		if (state_q == ST_READ && item_q.mode == MODE_WR_COL && col_ok && fac_ok)
			col_mem[caddr] <= item_q.value;
		if (state_q == ST_UPD && cnt_q != '0) begin
			row_mem[rbase + ROW_AW'(cnt_q) - ROW_AW'(1)] <= p_new;
			col_mem[cbase + COL_AW'(cnt_q) - COL_AW'(1)] <= q_new;
		end
	end

	always_comb begin
		err_c = clip32(64'(item_q.value) - sum, ef);
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: if (start) state_nx = ST_READ;
			ST_READ: begin
				if (item_q.mode == MODE_TRAIN && row_ok && col_ok)
					state_nx = ST_DOT;
				else
					state_nx = ST_DONE;
			end
			ST_DOT:  if (cnt_q == (FAC_W+1)'(FACTORS)) state_nx = ST_ERR;
			ST_ERR:  state_nx = ST_UPD;
			ST_UPD:  if (cnt_q == (FAC_W+1)'(FACTORS)) state_nx = ST_DONE;
			ST_DONE: state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// sequencer outputs; in ST_DOT the read data (prd_q/crd_q, rd_vld_s1) is registered
	// behind the counter, in ST_UPD the update result sits behind the s1 registers
	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_READ: ctrl.clr_acc = 1'b1;
			ST_DOT: begin
				ctrl.shift  = rd_vld_s1;
				ctrl.acc_en = rd_vld_s1;
			end
			ST_UPD: begin
				ctrl.shift = 1'b1;
				ctrl.upd   = (cnt_q < (FAC_W+1)'(FACTORS));
			end
			default: ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			esat_q    <= 1'b0;
			done      <= 1'b0;
		end else begin
			state_q   <= state_nx;
			done      <= (state_q == ST_DONE);
			rd_vld_s1 <= (state_q == ST_DOT) && (cnt_q < (FAC_W+1)'(FACTORS));
			case (state_q)
				ST_READ: cnt_q <= '0;
				ST_DOT:  cnt_q <= (cnt_q == (FAC_W+1)'(FACTORS)) ? '0 : cnt_q + 1'b1;
				ST_ERR:  esat_q <= ef;
				ST_UPD:  cnt_q <= cnt_q + 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) item_q <= in_word;
		if (state_q == ST_ERR) err_q <= err_c;
		if (state_q == ST_DONE) begin
			res_q <= '0;
			if (item_q.mode == MODE_TRAIN && row_ok && col_ok) res_q <= err_q;
			else if (item_q.mode == MODE_RD_ROW && row_ok && fac_ok) res_q <= prd_q;
			else if (item_q.mode == MODE_RD_COL && col_ok && fac_ok) res_q <= crd_q;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign out_word.result_value = res_q;
	assign out_word.saturated = (item_q.mode == MODE_TRAIN) && row_ok && col_ok &&
		(esat_q || usat);

endmodule
